[rtl/core/scpc_pkg.sv]
// Shared types and constants for the stepper command pulse controller.
// Depends on nothing; every module in rtl/core refers to it by scoped names.
package scpc_pkg;

   // Number of driven axes and the width of the visible step/dir line groups
   localparam int AXES      = 3;
   localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int LINE_W    = 3;

   // Frame buffer geometry
   localparam int FRAME_MAX = 7;
   localparam int CNT_W     = $clog2(FRAME_MAX + 1);
   localparam int IDX_W     = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;

   // Command opcodes as they appear in byte 0 of a frame
   localparam logic [7:0] OP_MOVE    = 8'h01;
   localparam logic [7:0] OP_ENABLE  = 8'h02;
   localparam logic [7:0] OP_DISABLE = 8'h03;
   localparam logic [7:0] AXIS_NONE  = 8'd255;

   // Kind of input word
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_BYTE  = 2'd1,
      FUNC_END   = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   // Pending command slot
   typedef struct packed {
      logic        valid;
      logic [1:0]  opcode;
      logic [7:0]  axis;
      logic        dir;
      logic [15:0] steps;
      logic [15:0] half_period;
   } pending_type;

   // Line levels after the current word has been applied
   typedef struct packed {
      logic [LINE_W-1:0] step_lines;
      logic [LINE_W-1:0] dir_lines;
      logic              enable_n;
      logic              moving;
   } lines_type;

endpackage

[rtl/core/scpc_frame_parser.sv]
// Frame collector and decoder: buffers command bytes, decodes a frame at its end
// and holds the single pending command slot. Depends on scpc_pkg.
module scpc_frame_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  scpc_pkg::func_type   func,
   input  logic [7:0]           data,
   input  logic                 consume,
   output scpc_pkg::pending_type pending
);

   logic [7:0]                  frame_bytes_ff [scpc_pkg::FRAME_MAX];
   logic [scpc_pkg::CNT_W-1:0]  frame_count_ff;
   logic [scpc_pkg::CNT_W-1:0]  frame_count_in;
   scpc_pkg::pending_type       pending_ff;
   scpc_pkg::pending_type       pending_in;
   logic                        byte_write;

   always_comb begin
      frame_count_in = frame_count_ff;
      pending_in     = pending_ff;
      byte_write     = 1'b0;
      if (accept) begin
         case (func)
            scpc_pkg::FUNC_BYTE: begin
               if (frame_count_ff < scpc_pkg::CNT_W'(scpc_pkg::FRAME_MAX)) begin
                  byte_write     = 1'b1;
                  frame_count_in = frame_count_ff + scpc_pkg::CNT_W'(1);
               end
            end
            scpc_pkg::FUNC_END: begin
               frame_count_in = '0;
               if (frame_count_ff != '0) begin
                  if (frame_bytes_ff[0] == scpc_pkg::OP_MOVE &&
                      frame_count_ff >= scpc_pkg::CNT_W'(scpc_pkg::FRAME_MAX)) begin
                     pending_in.valid       = 1'b1;
                     pending_in.opcode      = frame_bytes_ff[0][1:0];
                     pending_in.axis        = frame_bytes_ff[1];
                     pending_in.dir         = (frame_bytes_ff[2] != 8'd0);
                     pending_in.steps       = {frame_bytes_ff[4], frame_bytes_ff[3]};
                     pending_in.half_period = {frame_bytes_ff[6], frame_bytes_ff[5]};
                  end else if (frame_bytes_ff[0] == scpc_pkg::OP_ENABLE ||
                               frame_bytes_ff[0] == scpc_pkg::OP_DISABLE) begin
                     pending_in.valid       = 1'b1;
                     pending_in.opcode      = frame_bytes_ff[0][1:0];
                     // optional axis byte, otherwise the no-axis marker
                     pending_in.axis        = (frame_count_ff >= scpc_pkg::CNT_W'(2)) ?
                                              frame_bytes_ff[1] : scpc_pkg::AXIS_NONE;
                     pending_in.dir         = 1'b0;
                     pending_in.steps       = '0;
                     pending_in.half_period = '0;
                  end
               end
            end
            scpc_pkg::FUNC_TICK: begin
               if (consume) begin
                  pending_in.valid = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (byte_write) begin
         frame_bytes_ff[frame_count_ff[scpc_pkg::IDX_W-1:0]] <= data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         pending_ff     <= '0;
      end else begin
         frame_count_ff <= frame_count_in;
         pending_ff     <= pending_in;
      end
   end

   assign pending = pending_ff;

endmodule

[rtl/core/scpc_pulse_engine.sv]
// Pulse train engine: starts the pending command on a tick and times the step
// pulses, direction and enable levels. Depends on scpc_pkg.
module scpc_pulse_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick,
   input  scpc_pkg::pending_type pending,
   output logic                  consume,
   output scpc_pkg::lines_type   lines_next
);

   logic [scpc_pkg::AXIS_W-1:0] active_axis_ff, active_axis_in;
   logic [15:0]                 steps_left_ff, steps_left_in;
   logic [15:0]                 tick_counter_ff, tick_counter_in;
   logic [15:0]                 run_half_period_ff, run_half_period_in;
   logic                        pulse_high_ff, pulse_high_in;
   logic [scpc_pkg::LINE_W-1:0] dir_levels_ff, dir_levels_in;
   logic                        enable_level_ff, enable_level_in;
   logic                        running_ff, running_in;
   logic [15:0]                 count_dec;
   logic [15:0]                 start_half;

   assign consume   = tick && !running_ff && pending.valid;
   assign count_dec = (tick_counter_ff != 16'd0) ? tick_counter_ff - 16'd1 : 16'd0;
   assign start_half = (pending.half_period != 16'd0) ? pending.half_period : 16'd1;

   always_comb begin
      active_axis_in     = active_axis_ff;
      steps_left_in      = steps_left_ff;
      tick_counter_in    = tick_counter_ff;
      run_half_period_in = run_half_period_ff;
      pulse_high_in      = pulse_high_ff;
      dir_levels_in      = dir_levels_ff;
      enable_level_in    = enable_level_ff;
      running_in         = running_ff;
      if (tick && running_ff) begin
         tick_counter_in = count_dec;
         if (count_dec == 16'd0) begin
            if (pulse_high_ff) begin
               pulse_high_in   = 1'b0;
               if (steps_left_ff != 16'd0) begin
                  steps_left_in = steps_left_ff - 16'd1;
               end
               tick_counter_in = run_half_period_ff;
            end else if (steps_left_ff == 16'd0) begin
               running_in = 1'b0;
            end else begin
               pulse_high_in   = 1'b1;
               tick_counter_in = run_half_period_ff;
            end
         end
      end else if (consume) begin
         if (pending.opcode == scpc_pkg::OP_MOVE[1:0]) begin
            if (pending.axis < 8'(scpc_pkg::AXES)) begin
               enable_level_in = 1'b0;
               if (pending.steps != 16'd0) begin
                  for (int i = 0; i < scpc_pkg::LINE_W; i++) begin
                     if (pending.axis == 8'(i)) begin
                        dir_levels_in[i] = pending.dir;
                     end
                  end
                  active_axis_in     = pending.axis[scpc_pkg::AXIS_W-1:0];
                  steps_left_in      = pending.steps;
                  run_half_period_in = start_half;
                  tick_counter_in    = start_half;
                  pulse_high_in      = 1'b1;
                  running_in         = 1'b1;
               end
            end
         end else if (pending.opcode == scpc_pkg::OP_ENABLE[1:0]) begin
            enable_level_in = 1'b0;
         end else if (pending.opcode == scpc_pkg::OP_DISABLE[1:0]) begin
            enable_level_in = 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < scpc_pkg::LINE_W; i++) begin
         lines_next.step_lines[i] = running_in && pulse_high_in &&
                                    ({{(8 - scpc_pkg::AXIS_W){1'b0}}, active_axis_in} == 8'(i));
      end
      lines_next.dir_lines = dir_levels_in;
      lines_next.enable_n  = enable_level_in;
      lines_next.moving    = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_axis_ff     <= '0;
         steps_left_ff      <= '0;
         tick_counter_ff    <= '0;
         run_half_period_ff <= '0;
         pulse_high_ff      <= 1'b0;
         dir_levels_ff      <= '0;
         enable_level_ff    <= 1'b0;
         running_ff         <= 1'b0;
      end else begin
         active_axis_ff     <= active_axis_in;
         steps_left_ff      <= steps_left_in;
         tick_counter_ff    <= tick_counter_in;
         run_half_period_ff <= run_half_period_in;
         pulse_high_ff      <= pulse_high_in;
         dir_levels_ff      <= dir_levels_in;
         enable_level_ff    <= enable_level_in;
         running_ff         <= running_in;
      end
   end

endmodule

[rtl/core/stepper_command_pulse_controller.sv]
// Stepper command pulse controller, top level. Uses scpc_pkg, scpc_frame_parser
// and scpc_pulse_engine.
// The result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; the result register frees itself in the
// cycle it is taken, so req_tready stays high under a continuous drain.
// Reset: synchronous, active high; clears all control state, pulse lines low,
// drivers enabled, no pending command. The frame byte buffer is not cleared.
module stepper_command_pulse_controller (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic [1:0]  req_tuser,   // [1:0] func
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] step_lines, [5:3] dir_lines,
                                    // [6] enable_n, [7] read_data, [8] moving,
                                    // [15:9] zero
   output logic        rsp_tuser    // [0] read_valid
);

   logic                   accept;
   logic                   consume;
   scpc_pkg::func_type     func;
   scpc_pkg::pending_type  pending;
   scpc_pkg::lines_type    lines_next;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   scpc_pkg::lines_type    lines_ff;
   logic                   read_data_ff;
   logic                   read_valid_ff;

   // Take a new word whenever the result register is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign func       = scpc_pkg::func_type'(req_tuser);

   scpc_frame_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .func    (func),
      .data    (req_tdata),
      .consume (consume),
      .pending (pending)
   );

   // Ticks go to the engine only; bytes, frame ends and reads leave it alone.
   scpc_pulse_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .tick       (accept && func == scpc_pkg::FUNC_TICK),
      .pending    (pending),
      .consume    (consume),
      .lines_next (lines_next)
   );

   // Hold the result until taken; load a fresh one on every accepted word.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: lines after the word is applied; a read answers with the pending
   // flag, which a read itself never changes.
   always_ff @(posedge clock) begin
      if (accept) begin
         lines_ff      <= lines_next;
         read_valid_ff <= (func == scpc_pkg::FUNC_READ);
         read_data_ff  <= (func == scpc_pkg::FUNC_READ) && pending.valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = read_valid_ff;
   assign rsp_tdata  = {7'd0, lines_ff.moving, read_data_ff, lines_ff.enable_n,
                        lines_ff.dir_lines, lines_ff.step_lines};

endmodule
